// ===== hdl/bmp_stream_pixel_decoder_assert.svh =====
// Assertion macros used by the bitmap decoder checker.
`ifndef BMP_STREAM_PIXEL_DECODER_ASSERT_SVH
`define BMP_STREAM_PIXEL_DECODER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define BMPDEC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define BMPDEC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/bmpdec_pkg.sv =====
// Shared constants and types of the bitmap stream pixel decoder.
package bmpdec_pkg;

    localparam int MAX_DIM         = 4096;
    localparam int PALETTE_ENTRIES = 256;
    localparam int PAL_AW          = $clog2(PALETTE_ENTRIES);
    localparam int HDR_LEN         = 54;

    localparam logic [12:0] DIM_SAT = 13'd8191;

    localparam logic [7:0] SIG_B    = 8'h42;
    localparam logic [7:0] SIG_M    = 8'h4D;
    localparam logic [7:0] DEPTH_24 = 8'd24;
    localparam logic [7:0] DEPTH_8  = 8'd8;
    localparam logic [7:0] DEPTH_4  = 8'd4;
    localparam logic [7:0] DEPTH_1  = 8'd1;

    localparam logic [10:0] PAL_BYTES_8 = 11'(256 * 4);
    localparam logic [10:0] PAL_BYTES_4 = 11'(16 * 4);
    localparam logic [10:0] PAL_BYTES_1 = 11'(2 * 4);

    typedef enum logic [1:0]
    {
        ST_PIXEL     = 2'd0,
        ST_NOT_BMP   = 2'd1,
        ST_BAD_DEPTH = 2'd2,
        ST_TOO_LARGE = 2'd3
    } status_t;

    typedef struct packed
    {
        logic              use_pal;
        logic              idx_ok;
        logic [PAL_AW-1:0] addr;
        logic [23:0]       rgb;
        status_t           status;
        logic              run_last;
        logic              image_last;
    } job_t;

    typedef struct packed
    {
        logic              en;
        logic [PAL_AW-1:0] addr;
        logic [23:0]       rgb;
    } pal_wr_t;

endpackage

// ===== hdl/bmpdec_parser.sv =====
// Header and palette parser with per-pixel job issue for the bitmap decoder.
module bmpdec_parser
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [7:0]          data_byte,
    input  logic                file_start,
    input  logic                job_ready,
    output logic                in_stall,
    output logic                job_valid,
    output bmpdec_pkg::job_t    job,
    output bmpdec_pkg::pal_wr_t pal_wr
);

    typedef enum logic [1:0]
    {
        PH_HEADER,
        PH_PALETTE,
        PH_PIXELS,
        PH_IDLE
    } phase_t;

    localparam logic [10:0] OFF_SIG_B = 11'd0;
    localparam logic [10:0] OFF_SIG_M = 11'd1;
    localparam logic [10:0] OFF_W0    = 11'd18;
    localparam logic [10:0] OFF_W3    = 11'd21;
    localparam logic [10:0] OFF_H0    = 11'd22;
    localparam logic [10:0] OFF_H3    = 11'd25;
    localparam logic [10:0] OFF_DEPTH = 11'd28;
    localparam logic [10:0] OFF_LAST  = 11'(bmpdec_pkg::HDR_LEN - 1);

    function automatic logic [12:0] capture(logic [12:0] cur, logic [7:0] b, logic [1:0] pos);
        logic [15:0] v;
        v = {b, cur[7:0]};
        case (pos)
            2'd0:    capture = {5'd0, b};
            2'd1:    capture = (v > {3'd0, bmpdec_pkg::DIM_SAT}) ? bmpdec_pkg::DIM_SAT : v[12:0];
            default: capture = (b != 8'd0) ? bmpdec_pkg::DIM_SAT : cur;
        endcase
    endfunction

    function automatic logic too_large(logic [12:0] d);
        too_large = (d >= bmpdec_pkg::DIM_SAT) || ({1'b0, d} > 14'(bmpdec_pkg::MAX_DIM));
    endfunction

    function automatic bmpdec_pkg::job_t err_job(bmpdec_pkg::status_t s);
        bmpdec_pkg::job_t j;
        j          = '0;
        j.status   = s;
        j.run_last = 1'b1;
        err_job    = j;
    endfunction

    phase_t      phase_reg,      phase_next;
    logic [10:0] off_reg,        off_next;
    logic [12:0] width_reg,      width_next;
    logic [12:0] height_reg,     height_next;
    logic [7:0]  depth_reg,      depth_next;
    logic [25:0] pixels_left_reg, pixels_left_next;
    logic [15:0] partial_reg,    partial_next;
    logic [1:0]  triple_reg,     triple_next;
    logic [12:0] column_reg,     column_next;
    logic        exp_active_reg, exp_active_next;
    logic [7:0]  exp_byte_reg,   exp_byte_next;
    logic [2:0]  exp_k_reg,      exp_k_next;

    logic        in_fire;
    logic [7:0]  cur_byte;
    logic [2:0]  cur_k;
    logic [25:0] pl_dec;
    logic [12:0] col_inc;
    logic        img_end;
    logic        row_end;
    logic        step_end;
    logic [7:0]  pal_idx;
    logic [2:0]  last_k;
    logic        more;
    bmpdec_pkg::job_t pal_job;
    bmpdec_pkg::job_t rgb_job;

    phase_t      phase_eff;
    logic [10:0] off_eff;
    logic [12:0] width_eff;
    logic [12:0] height_eff;
    logic [7:0]  depth_eff;
    logic [12:0] width_hdr;
    logic [12:0] height_hdr;
    logic [7:0]  depth_hdr;
    logic        depth_ok;
    logic [25:0] area;

    logic [10:0] pal_pos;
    logic [8:0]  pal_entry;
    logic [10:0] off_inc;
    logic [10:0] pal_bytes;

    assign in_stall = exp_active_reg || !job_ready;
    assign in_fire  = in_valid && !in_stall;
    assign cur_byte = exp_active_reg ? exp_byte_reg : data_byte;
    assign cur_k    = exp_active_reg ? exp_k_reg : 3'd0;

    assign pl_dec   = pixels_left_reg - 26'd1;
    assign col_inc  = column_reg + 13'd1;
    assign img_end  = (pl_dec == 26'd0);
    assign row_end  = (col_inc >= width_reg);
    assign step_end = row_end || img_end;

    always_comb
    begin
        case (depth_reg)
            bmpdec_pkg::DEPTH_4:
            begin
                pal_idx = {4'd0, cur_k[0] ? cur_byte[3:0] : cur_byte[7:4]};
                last_k  = 3'd1;
            end
            bmpdec_pkg::DEPTH_1:
            begin
                pal_idx = {7'd0, cur_byte[3'd7 - cur_k]};
                last_k  = 3'd7;
            end
            default:
            begin
                pal_idx = cur_byte;
                last_k  = 3'd0;
            end
        endcase
    end

    assign more = !step_end && (cur_k != last_k);

    always_comb
    begin
        pal_job            = '0;
        pal_job.use_pal    = 1'b1;
        pal_job.idx_ok     = ({1'b0, pal_idx} < 9'(bmpdec_pkg::PALETTE_ENTRIES));
        pal_job.addr       = pal_idx[bmpdec_pkg::PAL_AW-1:0];
        pal_job.status     = bmpdec_pkg::ST_PIXEL;
        pal_job.run_last   = !more;
        pal_job.image_last = img_end;

        rgb_job            = '0;
        rgb_job.rgb        = {data_byte, partial_reg};
        rgb_job.status     = bmpdec_pkg::ST_PIXEL;
        rgb_job.run_last   = 1'b1;
        rgb_job.image_last = img_end;
    end

    assign phase_eff  = file_start ? PH_HEADER : phase_reg;
    assign off_eff    = file_start ? 11'd0 : off_reg;
    assign width_eff  = file_start ? 13'd0 : width_reg;
    assign height_eff = file_start ? 13'd0 : height_reg;
    assign depth_eff  = file_start ? 8'd0 : depth_reg;

    assign width_hdr  = (off_eff >= OFF_W0 && off_eff <= OFF_W3)
                      ? capture(width_eff, data_byte, 2'(off_eff - OFF_W0)) : width_eff;
    assign height_hdr = (off_eff >= OFF_H0 && off_eff <= OFF_H3)
                      ? capture(height_eff, data_byte, 2'(off_eff - OFF_H0)) : height_eff;
    assign depth_hdr  = (off_eff == OFF_DEPTH) ? data_byte : depth_eff;
    assign depth_ok   = (depth_eff == bmpdec_pkg::DEPTH_24) || (depth_eff == bmpdec_pkg::DEPTH_8)
                     || (depth_eff == bmpdec_pkg::DEPTH_4) || (depth_eff == bmpdec_pkg::DEPTH_1);
    assign area       = 26'({13'd0, width_eff} * {13'd0, height_eff});

    assign pal_pos   = off_reg - 11'(bmpdec_pkg::HDR_LEN);
    assign pal_entry = pal_pos[10:2];
    assign off_inc   = off_reg + 11'd1;

    always_comb
    begin
        case (depth_reg)
            bmpdec_pkg::DEPTH_8: pal_bytes = bmpdec_pkg::PAL_BYTES_8;
            bmpdec_pkg::DEPTH_4: pal_bytes = bmpdec_pkg::PAL_BYTES_4;
            bmpdec_pkg::DEPTH_1: pal_bytes = bmpdec_pkg::PAL_BYTES_1;
            default:             pal_bytes = 11'd0;
        endcase
    end

    always_comb
    begin
        phase_next       = phase_reg;
        off_next         = off_reg;
        width_next       = width_reg;
        height_next      = height_reg;
        depth_next       = depth_reg;
        pixels_left_next = pixels_left_reg;
        partial_next     = partial_reg;
        triple_next      = triple_reg;
        column_next      = column_reg;
        exp_active_next  = exp_active_reg;
        exp_byte_next    = exp_byte_reg;
        exp_k_next       = exp_k_reg;
        job_valid        = 1'b0;
        job              = '0;
        pal_wr           = '0;

        if (exp_active_reg)
        begin
            if (job_ready)
            begin
                job_valid        = 1'b1;
                job              = pal_job;
                pixels_left_next = pl_dec;
                column_next      = row_end ? 13'd0 : col_inc;
                if (img_end)
                    phase_next = PH_IDLE;
                exp_active_next  = more;
                exp_k_next       = cur_k + 3'd1;
            end
        end
        else if (in_fire)
        begin
            if (file_start)
            begin
                phase_next       = PH_HEADER;
                off_next         = 11'd0;
                width_next       = 13'd0;
                height_next      = 13'd0;
                depth_next       = 8'd0;
                pixels_left_next = 26'd0;
                partial_next     = 16'd0;
                triple_next      = 2'd0;
                column_next      = 13'd0;
            end
            case (phase_eff)
                PH_HEADER:
                begin
                    if ((off_eff == OFF_SIG_B && data_byte != bmpdec_pkg::SIG_B)
                        || (off_eff == OFF_SIG_M && data_byte != bmpdec_pkg::SIG_M))
                    begin
                        job_valid  = 1'b1;
                        job        = err_job(bmpdec_pkg::ST_NOT_BMP);
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        width_next  = width_hdr;
                        height_next = height_hdr;
                        depth_next  = depth_hdr;
                        off_next    = off_eff + 11'd1;
                        if (off_eff == OFF_LAST)
                        begin
                            if (!depth_ok)
                            begin
                                job_valid  = 1'b1;
                                job        = err_job(bmpdec_pkg::ST_BAD_DEPTH);
                                phase_next = PH_IDLE;
                            end
                            else if (too_large(width_eff) || too_large(height_eff))
                            begin
                                job_valid  = 1'b1;
                                job        = err_job(bmpdec_pkg::ST_TOO_LARGE);
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                pixels_left_next = area;
                                partial_next     = 16'd0;
                                if (depth_eff == bmpdec_pkg::DEPTH_24)
                                begin
                                    triple_next = 2'd0;
                                    column_next = 13'd0;
                                    phase_next  = (area == 26'd0) ? PH_IDLE : PH_PIXELS;
                                end
                                else
                                    phase_next = PH_PALETTE;
                            end
                        end
                    end
                end
                PH_PALETTE:
                begin
                    case (pal_pos[1:0])
                        2'd0: partial_next = {8'd0, data_byte};
                        2'd1: partial_next = {data_byte, partial_reg[7:0]};
                        2'd2:
                        begin
                            if (pal_entry < 9'(bmpdec_pkg::PALETTE_ENTRIES))
                            begin
                                pal_wr.en   = 1'b1;
                                pal_wr.addr = pal_entry[bmpdec_pkg::PAL_AW-1:0];
                                pal_wr.rgb  = {data_byte, partial_reg};
                            end
                        end
                        default: ;
                    endcase
                    off_next = off_inc;
                    if (off_inc >= 11'(bmpdec_pkg::HDR_LEN) + pal_bytes)
                    begin
                        triple_next  = 2'd0;
                        partial_next = 16'd0;
                        column_next  = 13'd0;
                        phase_next   = (pixels_left_reg == 26'd0) ? PH_IDLE : PH_PIXELS;
                    end
                end
                PH_PIXELS:
                begin
                    if (depth_reg == bmpdec_pkg::DEPTH_24)
                    begin
                        case (triple_reg)
                            2'd0:
                            begin
                                partial_next = {8'd0, data_byte};
                                triple_next  = 2'd1;
                            end
                            2'd1:
                            begin
                                partial_next = {data_byte, partial_reg[7:0]};
                                triple_next  = 2'd2;
                            end
                            default:
                            begin
                                triple_next      = 2'd0;
                                job_valid        = 1'b1;
                                job              = rgb_job;
                                pixels_left_next = pl_dec;
                                column_next      = row_end ? 13'd0 : col_inc;
                                if (img_end)
                                    phase_next = PH_IDLE;
                            end
                        endcase
                    end
                    else
                    begin
                        job_valid        = 1'b1;
                        job              = pal_job;
                        pixels_left_next = pl_dec;
                        column_next      = row_end ? 13'd0 : col_inc;
                        if (img_end)
                            phase_next = PH_IDLE;
                        exp_active_next  = more;
                        exp_byte_next    = data_byte;
                        exp_k_next       = 3'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_HEADER;
            off_reg         <= 11'd0;
            width_reg       <= 13'd0;
            height_reg      <= 13'd0;
            depth_reg       <= 8'd0;
            pixels_left_reg <= 26'd0;
            partial_reg     <= 16'd0;
            triple_reg      <= 2'd0;
            column_reg      <= 13'd0;
            exp_active_reg  <= 1'b0;
            exp_k_reg       <= 3'd0;
        end
        else
        begin
            phase_reg       <= phase_next;
            off_reg         <= off_next;
            width_reg       <= width_next;
            height_reg      <= height_next;
            depth_reg       <= depth_next;
            pixels_left_reg <= pixels_left_next;
            partial_reg     <= partial_next;
            triple_reg      <= triple_next;
            column_reg      <= column_next;
            exp_active_reg  <= exp_active_next;
            exp_k_reg       <= exp_k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        exp_byte_reg <= exp_byte_next;
    end

endmodule

// ===== hdl/bmpdec_pixel_pipe.sv =====
// Palette memory, lookup stage and output register of the bitmap decoder.
module bmpdec_pixel_pipe
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                job_valid,
    input  bmpdec_pkg::job_t    job,
    input  bmpdec_pkg::pal_wr_t pal_wr,
    output logic                job_ready,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [7:0]          red,
    output logic [7:0]          green,
    output logic [7:0]          blue,
    output logic [1:0]          status,
    output logic                run_last,
    output logic                image_last
);

    logic [23:0] mem [bmpdec_pkg::PALETTE_ENTRIES];
    logic [23:0] rd_data_reg;

    logic             s1_valid_reg;
    bmpdec_pkg::job_t s1_reg;
    logic             s2_valid_reg;
    logic [23:0]      rgb_reg;
    bmpdec_pkg::status_t status_reg;
    logic             run_last_reg;
    logic             image_last_reg;

    logic        s2_load;
    logic [23:0] s1_rgb;

    assign s2_load   = s1_valid_reg && (!s2_valid_reg || !out_stall);
    assign job_ready = !s1_valid_reg || s2_load;
    assign s1_rgb    = s1_reg.use_pal ? (s1_reg.idx_ok ? rd_data_reg : 24'd0) : s1_reg.rgb;

    always_ff @(posedge clk)
    begin
        if (pal_wr.en)
            mem[pal_wr.addr] <= pal_wr.rgb;
        if (job_valid && job.use_pal)
            rd_data_reg <= mem[job.addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (job_valid)
                s1_valid_reg <= 1'b1;
            else if (s2_load)
                s1_valid_reg <= 1'b0;
            if (s2_load)
                s2_valid_reg <= 1'b1;
            else if (!out_stall)
                s2_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_valid)
            s1_reg <= job;
        if (s2_load)
        begin
            rgb_reg        <= s1_rgb;
            status_reg     <= s1_reg.status;
            run_last_reg   <= s1_reg.run_last;
            image_last_reg <= s1_reg.image_last;
        end
    end

    assign out_valid  = s2_valid_reg;
    assign red        = rgb_reg[23:16];
    assign green      = rgb_reg[15:8];
    assign blue       = rgb_reg[7:0];
    assign status     = status_reg;
    assign run_last   = run_last_reg;
    assign image_last = image_last_reg;

endmodule

// ===== hdl/bmp_stream_pixel_decoder.sv =====
// Top level of the bitmap stream pixel decoder.
// Input beats carry one file byte in data_byte; file_start marks byte 0 of a file.
// Output beats carry one RGB pixel or one error code in status, with run_last on
// the last beat caused by an input byte and image_last on the final pixel.
// Both channels accept a beat at a rising edge with valid high and stall low.
// A result is registered first in the lookup stage, with the palette memory read,
// and then in the output register.
// Header, palette, 24-bit and 8-bit bytes are not expanded; a 4-bit byte gives
// up to two pixels and a 1-bit byte up to eight, one pixel per cycle while
// job_ready is high, set by the single read port of the palette memory. in_stall
// stays high while a packed byte is still being expanded.
// When the receiver stalls, the output beat holds and the lookup stage fills;
// after that in_stall rises until the output drains.
// Reset clears the parser to expect a header and empties the pipeline; the
// palette contents are undefined until a file loads them.
module bmp_stream_pixel_decoder
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       file_start,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] red,
    output logic [7:0] green,
    output logic [7:0] blue,
    output logic [1:0] status,
    output logic       run_last,
    output logic       image_last
);

    logic                job_ready;
    logic                job_valid;
    bmpdec_pkg::job_t    job;
    bmpdec_pkg::pal_wr_t pal_wr;

    bmpdec_parser u_parser
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .data_byte  (data_byte),
        .file_start (file_start),
        .job_ready  (job_ready),
        .in_stall   (in_stall),
        .job_valid  (job_valid),
        .job        (job),
        .pal_wr     (pal_wr)
    );

    bmpdec_pixel_pipe u_pixel_pipe
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_valid  (job_valid),
        .job        (job),
        .pal_wr     (pal_wr),
        .job_ready  (job_ready),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .status     (status),
        .run_last   (run_last),
        .image_last (image_last)
    );

endmodule

// ===== hdl/bmpdec_checker.sv =====
// Port-level assertions for the bitmap decoder and their bind.
`include "bmp_stream_pixel_decoder_assert.svh"

module bmpdec_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [7:0] data_byte,
    input logic       file_start,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] red,
    input logic [7:0] green,
    input logic [7:0] blue,
    input logic [1:0] status,
    input logic       run_last,
    input logic       image_last
);

    logic is_error;
    logic in_idle_ok;

    assign is_error   = (status != bmpdec_pkg::ST_PIXEL);
    assign in_idle_ok = !in_valid || in_stall || (data_byte == data_byte) || file_start;

    `BMPDEC_ASSERT_IMPL(a_error_beat_clean, out_valid && is_error, red == 8'd0 && green == 8'd0 && blue == 8'd0 && run_last && !image_last && in_idle_ok, "error beat carries color or image end")
    `BMPDEC_ASSERT_IMPL(a_image_end_ends_run, out_valid && image_last, run_last && !is_error, "image end without run end")
    `BMPDEC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(red) && $stable(green) && $stable(blue) && $stable(status) && $stable(run_last) && $stable(image_last), "stalled output beat changed")

endmodule

bind bmp_stream_pixel_decoder bmpdec_checker u_checker (.*);
